// ===== rtl/plcs_pkg.sv =====
// Shared types, widths and codes for the chained pipeline latency summer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package plcs_pkg;

  localparam int DEF_MAX_STEPS     = 8;
  localparam int DEF_HISTORY_DEPTH = 16;

  localparam int TS_W        = 63;  // timestamps in ns
  localparam int LAT_IN_W    = 24;  // raw signed latency in us
  localparam int LAT_W       = 23;  // scaled, clamped latency in us
  localparam int LAT_NS_W    = 33;  // scaled latency in ns
  localparam int TOTAL_W     = 25;
  localparam int THR_W       = 24;
  localparam int GAIN_W      = 8;
  localparam int GAIN_FRAC   = 4;   // Q4.4
  localparam int TABLE_STEPS = 8;   // steps covered by the mask and gain registers
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [LAT_W-1:0] LAT_MAX   = '1;
  localparam logic [9:0]       NS_PER_US = 10'd1000;

  localparam logic CMD_RECORD   = 1'b0;
  localparam logic CMD_EVALUATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_COUNT    = 3'd0,
    REG_WINDOW_LENGTH = 3'd1,
    REG_START_MASK    = 3'd2,
    REG_GAIN_TABLE    = 3'd3,
    REG_OFFSET        = 3'd4,
    REG_THRESHOLD     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_OVER    = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]               step_count;
    logic [4:0]               window_length;
    logic [TABLE_STEPS-1:0]   start_mask;
    logic [CFG_DATA_W-1:0]    gain_table;
    logic signed [THR_W-1:0]  offset_us;
    logic [THR_W-1:0]         threshold_us;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch the request fields
    logic rec_scale;  // gain and clamp the sample latency
    logic rec_write;  // push sample into its step history
    logic clear;      // start of evaluate: clear sum, latch missing mask
    logic rd_en;      // read one history entry
    logic load_now;   // start bound from now_ns
    logic take;       // add entry latency, move bound to its start
    logic finish;     // offset, saturate, status, publish
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;        // entry read last cycle ends before the bound
    logic cur_empty;  // current step has no samples
  } dp_stat_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pipeline_latency_chain_summer_unit.sv =====
// Top level of the chained pipeline latency summer.
// Depends on plcs_pkg, plcs_cfg_regs, plcs_ctrl and plcs_datapath.
//
// Usage:
//  Requests: a request is taken on a clock edge with start high and busy low.
//  command = record pushes one sample (step_index, sample_time_ns,
//  latency_in_us); command = evaluate chains samples of all steps in use
//  back from the last step's newest (now_ns if empty) and gives one result.
//  A record keeps busy high through its scale and write states and gives no
//  result. An evaluate keeps busy high while it takes the last step's newest
//  entry, scans each earlier step newest to oldest until an entry ends before
//  the bound or none is left, then finishes. The result appears in the first
//  cycle with busy low, shown for one cycle with done high. Busy time is set
//  by the history walk, one entry per cycle through the single memory read port.
//  A new request may be taken in the cycle done is high.
//  Configuration: cfg_ready is always high; write only while busy is low.
//  Reset (rst, synchronous): configuration returns to defaults, every step
//  history is empty, no result is pending. The receiver cannot stall: done
//  lasts one cycle and the result must be taken then.
`timescale 1ns / 1ps
`default_nettype none

module pipeline_latency_chain_summer_unit import plcs_pkg::*; #(
  parameter int MAX_STEPS     = DEF_MAX_STEPS,
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic [2:0]                  step_index,
  input  logic [TS_W-1:0]             sample_time_ns,
  input  logic signed [LAT_IN_W-1:0]  latency_in_us,
  input  logic [TS_W-1:0]             now_ns,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output logic                        done,
  output logic signed [TOTAL_W-1:0]   total_latency_us,
  output logic [TABLE_STEPS-1:0]      missing_mask,
  output logic [1:0]                  status_code
);

  localparam int STEP_W = idx_w(MAX_STEPS);
  localparam int SLOT_W = idx_w(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

  cfg_t              cfg;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [STEP_W-1:0] last_step;
  logic [STEP_W-1:0] cur_step;
  logic [FILL_W-1:0] cur_fill;
  logic [SLOT_W-1:0] cur_wslot;
  logic [SLOT_W-1:0] rd_slot;

  plcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  plcs_ctrl #(
    .MAX_STEPS     (MAX_STEPS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .busy      (busy),
    .last_step (last_step),
    .cur_fill  (cur_fill),
    .cur_wslot (cur_wslot),
    .stat      (stat),
    .cmd       (cmd),
    .cur_step  (cur_step),
    .rd_slot   (rd_slot)
  );

  plcs_datapath #(
    .MAX_STEPS     (MAX_STEPS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .step_index       (step_index),
    .sample_time_ns   (sample_time_ns),
    .latency_in_us    (latency_in_us),
    .now_ns           (now_ns),
    .cur_step         (cur_step),
    .rd_slot          (rd_slot),
    .stat             (stat),
    .last_step        (last_step),
    .cur_fill         (cur_fill),
    .cur_wslot        (cur_wslot),
    .done             (done),
    .total_latency_us (total_latency_us),
    .missing_mask     (missing_mask),
    .status_code      (status_code)
  );

  // a result only ever closes a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding busy period");

  // a record keeps busy through its scale and write states and never yields a result
  a_record_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_RECORD) |=> busy ##1 busy ##1 (!busy && !done))
    else $error("record request did not complete silently in two cycles");

  // any missing step forces the missing status
  a_missing_status: assert property (@(posedge clk) disable iff (rst)
    (done && missing_mask != '0) |-> (status_code == STATUS_MISSING))
    else $error("missing steps reported without missing status");

endmodule

`default_nettype wire

// ===== rtl/plcs_cfg_regs.sv =====
// Configuration register bank of the chained latency summer.
// Depends on plcs_pkg for the register map and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module plcs_cfg_regs import plcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_count    <= 4'd1;
      cfg.window_length <= 5'd16;
      cfg.start_mask    <= '0;
      cfg.gain_table    <= 64'h1010_1010_1010_1010;
      cfg.offset_us     <= '0;
      cfg.threshold_us  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_COUNT:    cfg.step_count    <= cfg_data[3:0];
        REG_WINDOW_LENGTH: cfg.window_length <= cfg_data[4:0];
        REG_START_MASK:    cfg.start_mask    <= cfg_data[TABLE_STEPS-1:0];
        REG_GAIN_TABLE:    cfg.gain_table    <= cfg_data;
        REG_OFFSET:        cfg.offset_us     <= $signed(cfg_data[THR_W-1:0]);
        REG_THRESHOLD:     cfg.threshold_us  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/plcs_ctrl.sv =====
// Controller of the chained latency summer: sequences record and evaluate
// requests, walks steps last to first and history newest to oldest.
// Depends on plcs_pkg (dp_cmd_t, dp_stat_t, codes).
`timescale 1ns / 1ps
`default_nettype none

module plcs_ctrl import plcs_pkg::*; #(
  parameter int MAX_STEPS     = DEF_MAX_STEPS,
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 command,
  output logic                                 busy,
  input  logic [idx_w(MAX_STEPS)-1:0]          last_step,
  input  logic [$clog2(HISTORY_DEPTH+1)-1:0]   cur_fill,
  input  logic [idx_w(HISTORY_DEPTH)-1:0]      cur_wslot,
  input  dp_stat_t                             stat,
  output dp_cmd_t                              cmd,
  output logic [idx_w(MAX_STEPS)-1:0]          cur_step,
  output logic [idx_w(HISTORY_DEPTH)-1:0]      rd_slot
);

  localparam int STEP_W = idx_w(MAX_STEPS);
  localparam int SLOT_W = idx_w(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_REC_SCALE  = 8'b0000_0010,
    S_REC_WRITE  = 8'b0000_0100,
    S_EV_START   = 8'b0000_1000,
    S_EV_LAST    = 8'b0001_0000,
    S_STEP_BEGIN = 8'b0010_0000,
    S_SCAN       = 8'b0100_0000,
    S_FINISH     = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [STEP_W-1:0] cur, cur_next;
  logic [SLOT_W-1:0] ptr, ptr_next;
  logic [FILL_W-1:0] jcnt, jcnt_next;
  logic [FILL_W-1:0] flim, flim_next;
  logic              advance;

  function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
    return (s == '0) ? LAST_SLOT : SLOT_W'(s - 1'b1);
  endfunction

  assign busy     = (state != S_IDLE);
  assign cur_step = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
      ptr   <= '0;
      jcnt  <= '0;
      flim  <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      ptr   <= ptr_next;
      jcnt  <= jcnt_next;
      flim  <= flim_next;
    end
  end

  always_comb begin
    state_next = state;
    cur_next   = cur;
    ptr_next   = ptr;
    jcnt_next  = jcnt;
    flim_next  = flim;
    cmd        = '0;
    rd_slot    = ptr;
    advance    = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          cur_next    = last_step;
          state_next  = (command == CMD_EVALUATE) ? S_EV_START : S_REC_SCALE;
        end
      end
      S_REC_SCALE: begin
        cmd.rec_scale = 1'b1;
        state_next    = S_REC_WRITE;
      end
      S_REC_WRITE: begin
        cmd.rec_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_EV_START: begin
        cmd.clear = 1'b1;
        if (stat.cur_empty) begin
          cmd.load_now = 1'b1;
          advance      = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          rd_slot    = prev_slot(cur_wslot);
          state_next = S_EV_LAST;
        end
      end
      S_EV_LAST: begin
        cmd.take = 1'b1;
        advance  = 1'b1;
      end
      S_STEP_BEGIN: begin
        if (stat.cur_empty) begin
          advance = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          rd_slot    = prev_slot(cur_wslot);
          ptr_next   = prev_slot(prev_slot(cur_wslot));
          jcnt_next  = FILL_W'(1);
          flim_next  = cur_fill;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // data of the entry requested last cycle is on the read port now
        if (stat.hit) begin
          cmd.take = 1'b1;
          advance  = 1'b1;
        end else if (jcnt == flim) begin
          advance = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
          rd_slot   = ptr;
          ptr_next  = prev_slot(ptr);
          jcnt_next = jcnt + 1'b1;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (advance) begin
      if (cur == '0) begin
        state_next = S_FINISH;
      end else begin
        cur_next   = cur - 1'b1;
        state_next = S_STEP_BEGIN;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/plcs_datapath.sv =====
// Datapath of the chained latency summer: request latches, sample scaling,
// per-step history memory, chain compare, sum and result registers.
// Depends on plcs_pkg; driven by plcs_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module plcs_datapath import plcs_pkg::*; #(
  parameter int MAX_STEPS     = DEF_MAX_STEPS,
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cfg_t                                 cfg,
  input  dp_cmd_t                              cmd,
  input  logic [2:0]                           step_index,
  input  logic [TS_W-1:0]                      sample_time_ns,
  input  logic signed [LAT_IN_W-1:0]           latency_in_us,
  input  logic [TS_W-1:0]                      now_ns,
  input  logic [idx_w(MAX_STEPS)-1:0]          cur_step,
  input  logic [idx_w(HISTORY_DEPTH)-1:0]      rd_slot,
  output dp_stat_t                             stat,
  output logic [idx_w(MAX_STEPS)-1:0]          last_step,
  output logic [$clog2(HISTORY_DEPTH+1)-1:0]   cur_fill,
  output logic [idx_w(HISTORY_DEPTH)-1:0]      cur_wslot,
  output logic                                 done,
  output logic signed [TOTAL_W-1:0]            total_latency_us,
  output logic [TABLE_STEPS-1:0]               missing_mask,
  output logic [1:0]                           status_code
);

  localparam int STEP_W = idx_w(MAX_STEPS);
  localparam int SLOT_W = idx_w(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W  = ($clog2(MAX_STEPS + 1) > 3) ? $clog2(MAX_STEPS + 1) : 3;
  localparam int CMP_W  = ((FILL_W > 5) ? FILL_W : 5) + 1;
  localparam int SCW    = ($clog2(MAX_STEPS + 1) > 4) ? $clog2(MAX_STEPS + 1) : 4;
  localparam int PROD_W = LAT_W + GAIN_W;
  localparam int SUM_W  = LAT_W + $clog2(MAX_STEPS + 1);
  localparam int ACC_W  = SUM_W + 2;
  localparam int BND_W  = TS_W + 2;
  localparam int WORD_W = TS_W + LAT_W + LAT_NS_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((64'sd1 <<< (TOTAL_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ~ACC_MAX;

  // request latches
  logic [2:0]                  in_step;
  logic [TS_W-1:0]             in_ts;
  logic signed [LAT_IN_W-1:0]  in_lat;
  logic [TS_W-1:0]             in_now;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_step <= step_index;
      in_ts   <= sample_time_ns;
      in_lat  <= latency_in_us;
      in_now  <= now_ns;
    end
  end

  // ---------------- record path ----------------
  logic [IDX_W-1:0]    in_step_wide;
  logic                rec_ok;
  logic [STEP_W-1:0]   rec_step;
  logic [GAIN_W-1:0]   rec_gain;
  logic [PROD_W-1:0]   rec_prod;
  logic [PROD_W-GAIN_FRAC-1:0] rec_shift;
  logic [LAT_W-1:0]    rec_scaled;
  logic [LAT_W-1:0]    rec_lat;
  logic [LAT_NS_W-1:0] rec_lat_ns;

  assign in_step_wide = IDX_W'(in_step);
  assign rec_ok       = (in_step_wide < IDX_W'(MAX_STEPS));
  assign rec_step     = in_step_wide[STEP_W-1:0];
  assign rec_gain     = cfg.gain_table[in_step*GAIN_W +: GAIN_W];

  always_comb begin
    // negative latencies clamp to zero before the gain
    rec_prod  = in_lat[LAT_IN_W-1] ? '0
              : ({{GAIN_W{1'b0}}, in_lat[LAT_W-1:0]} * {{LAT_W{1'b0}}, rec_gain});
    rec_shift = rec_prod[PROD_W-1:GAIN_FRAC];
    rec_scaled = (rec_shift[PROD_W-GAIN_FRAC-1:LAT_W] != '0) ? LAT_MAX
               : rec_shift[LAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_scale) rec_lat <= rec_scaled;
  end

  assign rec_lat_ns = {{(LAT_NS_W-LAT_W){1'b0}}, rec_lat} * {{(LAT_NS_W-10){1'b0}}, NS_PER_US};

  // per-step ring state
  logic [FILL_W-1:0] fill  [MAX_STEPS];
  logic [SLOT_W-1:0] wslot [MAX_STEPS];
  logic [CMP_W-1:0]  win, fplus;
  logic [FILL_W-1:0] fill_next;
  logic [SLOT_W-1:0] wslot_next;

  always_comb begin
    win = (CMP_W'(cfg.window_length) > CMP_W'(HISTORY_DEPTH)) ? CMP_W'(HISTORY_DEPTH)
        : CMP_W'(cfg.window_length);
    fplus      = CMP_W'(fill[rec_step]) + 1'b1;
    fill_next  = FILL_W'((fplus > win) ? win : fplus);
    wslot_next = (wslot[rec_step] == LAST_SLOT) ? '0 : SLOT_W'(wslot[rec_step] + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_STEPS; i++) begin
        fill[i]  <= '0;
        wslot[i] <= '0;
      end
    end else if (cmd.rec_write && rec_ok) begin
      fill[rec_step]  <= fill_next;
      wslot[rec_step] <= wslot_next;
    end
  end

  // history memory: {timestamp, latency us, latency ns}
  logic [WORD_W-1:0] hist_mem [MAX_STEPS][HISTORY_DEPTH];
  logic [WORD_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (cmd.rec_write && rec_ok) begin
      hist_mem[rec_step][wslot[rec_step]] <= {in_ts, rec_lat, rec_lat_ns};
    end
    if (cmd.rd_en) begin
      rd_word <= hist_mem[cur_step][rd_slot];
    end
  end

  // ---------------- evaluate path ----------------
  logic [SCW-1:0]           n_steps;
  logic [TABLE_STEPS-1:0]   miss_now;
  logic [MAX_STEPS-1:0]     mask_ext;

  always_comb begin
    if (cfg.step_count == '0) begin
      n_steps = SCW'(1);
    end else if (SCW'(cfg.step_count) > SCW'(MAX_STEPS)) begin
      n_steps = SCW'(MAX_STEPS);
    end else begin
      n_steps = SCW'(cfg.step_count);
    end
  end

  assign last_step = STEP_W'(n_steps - 1'b1);

  for (genvar g = 0; g < TABLE_STEPS; g++) begin : g_miss
    if (g < MAX_STEPS) begin : g_used
      assign miss_now[g] = (n_steps > SCW'(g)) && (fill[g] == '0);
    end else begin : g_none
      assign miss_now[g] = 1'b0;
    end
  end

  // steps past the mask register always timestamp the end
  for (genvar g = 0; g < MAX_STEPS; g++) begin : g_mask
    if (g < TABLE_STEPS) begin : g_tab
      assign mask_ext[g] = cfg.start_mask[g];
    end else begin : g_off
      assign mask_ext[g] = 1'b0;
    end
  end

  assign cur_fill       = fill[cur_step];
  assign cur_wslot      = wslot[cur_step];
  assign stat.cur_empty = (cur_fill == '0);

  logic [TS_W-1:0]          rd_ts;
  logic [LAT_W-1:0]         rd_lat;
  logic [LAT_NS_W-1:0]      rd_lat_ns;
  logic                     ms;
  logic [TS_W:0]            end_t;
  logic signed [BND_W-1:0]  start_t;
  logic signed [BND_W-1:0]  bound;
  logic [SUM_W-1:0]         sum;
  logic [TABLE_STEPS-1:0]   missing;

  assign {rd_ts, rd_lat, rd_lat_ns} = rd_word;
  assign ms = mask_ext[cur_step];

  always_comb begin
    end_t   = {1'b0, rd_ts} + (ms ? (TS_W+1)'(rd_lat_ns) : '0);
    start_t = ms ? $signed({2'b00, rd_ts})
            : $signed({2'b00, rd_ts} - BND_W'(rd_lat_ns));
  end

  // bound is signed: an entry's start may fall below zero
  assign stat.hit = ($signed({1'b0, end_t}) < bound);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      sum     <= '0;
      missing <= miss_now;
    end
    if (cmd.load_now) begin
      bound <= $signed({2'b00, in_now});
    end
    if (cmd.take) begin
      sum   <= sum + SUM_W'(rd_lat);
      bound <= start_t;
    end
  end

  // ---------------- finish ----------------
  logic signed [ACC_W-1:0]   acc;
  logic signed [TOTAL_W-1:0] tot_sat;
  status_t                   st;

  always_comb begin
    acc = $signed({2'b00, sum}) + ACC_W'(cfg.offset_us);
    if (acc > ACC_MAX) begin
      tot_sat = ACC_MAX[TOTAL_W-1:0];
    end else if (acc < ACC_MIN) begin
      tot_sat = ACC_MIN[TOTAL_W-1:0];
    end else begin
      tot_sat = acc[TOTAL_W-1:0];
    end
    if (missing != '0) begin
      st = STATUS_MISSING;
    end else if ($signed({tot_sat[TOTAL_W-1], tot_sat}) >
                 $signed({2'b00, cfg.threshold_us})) begin
      st = STATUS_OVER;
    end else begin
      st = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      total_latency_us <= tot_sat;
      missing_mask     <= missing;
      status_code      <= st;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for pipeline_latency_chain_summer_unit: directed and random requests
// checked against an untimed model of the step histories and the chained walk.
// Depends on plcs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import plcs_pkg::*;

  localparam int              N_STEPS     = DEF_MAX_STEPS;
  localparam int              N_SLOTS     = DEF_HISTORY_DEPTH;
  localparam int              CYCLE_LIMIT = 600000;
  localparam int              SETTLE      = 8;
  localparam int              TAIL        = 130;
  localparam int              PEND_DEPTH  = 16;
  localparam logic [63:0]     TIME_BIAS   = 64'd1 << 40;
  localparam logic [TS_W-1:0] TS_MAX      = '1;
  localparam logic [TS_W-1:0] STRIDE_NS   = 63'd4_000_000;
  localparam logic [TS_W-1:0] ROUND_NS    = 63'd36_000_000;
  localparam longint          TOTAL_HI    = 16777215;
  localparam longint          TOTAL_LO    = -16777216;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total;
    logic [TABLE_STEPS-1:0]    missing;
    status_t                   status;
  } chain_result_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       command;
  logic [2:0]                 step_index;
  logic [TS_W-1:0]            sample_time_ns;
  logic signed [LAT_IN_W-1:0] latency_in_us;
  logic [TS_W-1:0]            now_ns;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       done;
  logic signed [TOTAL_W-1:0]  total_latency_us;
  logic [TABLE_STEPS-1:0]     missing_mask;
  logic [1:0]                 status_code;

  // model state: register mirror and per-step sample rings
  cfg_t             model_cfg;
  logic [TS_W-1:0]  hist_time [N_STEPS][N_SLOTS];
  logic [LAT_W-1:0] hist_lat  [N_STEPS][N_SLOTS];
  logic [4:0]       hist_fill [N_STEPS];
  logic [3:0]       hist_wr   [N_STEPS];

  // predicted results in request order; pend_wr - pend_rd are outstanding
  chain_result_t pending_totals [PEND_DEPTH];
  int            pend_wr     = 0;
  int            pend_rd     = 0;
  chain_result_t due;
  int            err_count   = 0;
  int            cycle_count = 0;
  bit            gaps_on     = 1'b1;

  pipeline_latency_chain_summer_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .step_index       (step_index),
    .sample_time_ns   (sample_time_ns),
    .latency_in_us    (latency_in_us),
    .now_ns           (now_ns),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .done             (done),
    .total_latency_us (total_latency_us),
    .missing_mask     (missing_mask),
    .status_code      (status_code)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [TS_W-1:0] rand_time();
    return TS_W'({$urandom, $urandom});
  endfunction

  function automatic logic [63:0] lat_ns(input logic [LAT_W-1:0] lat);
    return 64'(lat) * 64'(NS_PER_US);
  endfunction

  // k-th newest slot of a step ring, k = 0 is the newest
  function automatic int newest_slot(input int s, input int k);
    return (int'(hist_wr[s]) + 2 * N_SLOTS - 1 - k) % N_SLOTS;
  endfunction

  task automatic record_sample(input logic [2:0] s, input logic [TS_W-1:0] ts,
                               input logic signed [LAT_IN_W-1:0] raw);
    longint scaled;
    int     win;
    int     fill;
    win = (model_cfg.window_length > N_SLOTS) ? N_SLOTS : int'(model_cfg.window_length);
    scaled = 0;
    if (raw > 0)
      scaled = (longint'(raw) * longint'(model_cfg.gain_table[s*GAIN_W +: GAIN_W]))
               >> GAIN_FRAC;
    if (scaled > longint'(LAT_MAX)) scaled = longint'(LAT_MAX);
    hist_time[s][hist_wr[s]] = ts;
    hist_lat[s][hist_wr[s]]  = scaled[LAT_W-1:0];
    hist_wr[s] = hist_wr[s] + 1'b1;
    fill = int'(hist_fill[s]) + 1;
    if (fill > win) fill = win;
    hist_fill[s] = fill[4:0];
  endtask

  function automatic chain_result_t chain_total(input logic [TS_W-1:0] now);
    chain_result_t    res;
    int               n;
    int               s;
    int               j;
    int               k;
    int               depth;
    bit               found;
    logic [LAT_W-1:0] lat;
    logic [63:0]      t;
    logic [63:0]      t_end;
    logic [63:0]      bound;
    longint           sum;
    n = int'(model_cfg.step_count);
    if (n == 0) n = 1;
    if (n > N_STEPS) n = N_STEPS;
    sum = 0;
    res.missing = '0;
    for (s = 0; s < n; s++)
      if (hist_fill[s] == 0) res.missing[s] = 1'b1;
    s = n - 1;
    if (hist_fill[s] != 0) begin
      k = newest_slot(s, 0);
      lat = hist_lat[s][k];
      sum += longint'(lat);
      bound = {1'b0, hist_time[s][k]} + TIME_BIAS;
      if (!model_cfg.start_mask[s]) bound -= lat_ns(lat);
    end else begin
      bound = {1'b0, now} + TIME_BIAS;
    end
    // walk back: each earlier step gives its newest sample ending before the bound
    while (s > 0) begin
      s--;
      depth = (hist_fill[s] > N_SLOTS) ? N_SLOTS : int'(hist_fill[s]);
      found = 1'b0;
      for (j = 0; j < depth && !found; j++) begin
        k = newest_slot(s, j);
        lat = hist_lat[s][k];
        t = {1'b0, hist_time[s][k]} + TIME_BIAS;
        t_end = model_cfg.start_mask[s] ? t + lat_ns(lat) : t;
        if (t_end < bound) begin
          sum += longint'(lat);
          bound = model_cfg.start_mask[s] ? t : t - lat_ns(lat);
          found = 1'b1;
        end
      end
    end
    sum += longint'($signed(model_cfg.offset_us));
    if (sum > TOTAL_HI) sum = TOTAL_HI;
    if (sum < TOTAL_LO) sum = TOTAL_LO;
    res.total = sum[TOTAL_W-1:0];
    if (res.missing != 0) res.status = STATUS_MISSING;
    else if (sum > longint'(model_cfg.threshold_us)) res.status = STATUS_OVER;
    else res.status = STATUS_OK;
    return res;
  endfunction

  // Entered and left on a rising edge; start stays high when requests follow back to back.
  task automatic send_request(input logic cmd, input logic [2:0] s,
                              input logic [TS_W-1:0] ts,
                              input logic signed [LAT_IN_W-1:0] lat,
                              input logic [TS_W-1:0] now);
    int gap;
    if (gaps_on && $urandom_range(0, 99) < 29) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 130) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    command        <= cmd;
    step_index     <= s;
    sample_time_ns <= ts;
    latency_in_us  <= lat;
    now_ns         <= now;
    do @(posedge clk); while (busy !== 1'b0);
    if (cmd == CMD_EVALUATE) begin
      pending_totals[pend_wr % PEND_DEPTH] = chain_total(now);
      pend_wr++;
    end else begin
      record_sample(s, ts, lat);
    end
  endtask

  task automatic push_sample(input logic [2:0] s, input logic [TS_W-1:0] ts,
                             input logic signed [LAT_IN_W-1:0] lat);
    send_request(CMD_RECORD, s, ts, lat, rand_time());
  endtask

  task automatic evaluate_at(input logic [TS_W-1:0] now);
    send_request(CMD_EVALUATE, 3'($urandom), rand_time(), LAT_IN_W'($urandom), now);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STEP_COUNT:    model_cfg.step_count    = data[3:0];
      REG_WINDOW_LENGTH: model_cfg.window_length = data[4:0];
      REG_START_MASK:    model_cfg.start_mask    = data[TABLE_STEPS-1:0];
      REG_GAIN_TABLE:    model_cfg.gain_table    = data;
      REG_OFFSET:        model_cfg.offset_us     = data[THR_W-1:0];
      REG_THRESHOLD:     model_cfg.threshold_us  = data[THR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // hold requests until every result is back and the last record has retired
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pend_wr != pend_rd || busy !== 1'b0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    evaluate_at(63'd0);                         // nothing recorded yet
    push_sample(3'd0, TS_MAX, 24'h7F_FFFF);
    evaluate_at(TS_MAX);
    push_sample(3'd0, 63'd0, 24'h80_0000);      // negative latency clamps to zero
    evaluate_at(63'd0);
  endtask

  task automatic test_register_extremes();
    int s;
    wait_idle();
    write_reg(REG_STEP_COUNT, 64'd8);
    write_reg(REG_WINDOW_LENGTH, 64'd16);
    write_reg(REG_START_MASK, 64'hFF);
    write_reg(REG_GAIN_TABLE, '1);
    write_reg(REG_OFFSET, 64'h7F_FFFF);
    write_reg(REG_THRESHOLD, 64'hFF_FFFF);
    // max gain on max latency saturates; spacing lets every step chain
    for (s = 0; s < N_STEPS; s++)
      push_sample(3'(s), TS_W'(s) * 63'd10_000_000_000, 24'h7F_FFFF);
    evaluate_at(TS_MAX);
    wait_idle();
    write_reg(REG_STEP_COUNT, 64'd15);          // clamps to all steps
    write_reg(REG_START_MASK, 64'h5A);
    write_reg(REG_GAIN_TABLE, 64'd0);
    write_reg(REG_OFFSET, 64'hFFFF_FFFF_FF80_0000);
    write_reg(REG_THRESHOLD, 64'd0);
    push_sample(3'd3, 63'd0, 24'sd1000);
    evaluate_at(63'd0);
  endtask

  task automatic test_window_rules();
    wait_idle();
    write_reg(REG_STEP_COUNT, 64'd0);           // read as one step
    write_reg(REG_WINDOW_LENGTH, 64'd0);        // keeps nothing
    write_reg(REG_OFFSET, 64'd0);
    push_sample(3'd0, 63'd123, 24'sd500);
    evaluate_at(63'd0);
    wait_idle();
    write_reg(REG_STEP_COUNT, 64'd2);
    write_reg(REG_WINDOW_LENGTH, 64'd31);       // clamps to ring depth
    write_reg(REG_START_MASK, 64'd0);
    write_reg(REG_GAIN_TABLE, 64'h1010_1010_1010_1010);
    push_sample(3'd0, 63'd1_000_000, 24'sd100);
    push_sample(3'd0, 63'd2_000_000, 24'sd100);
    push_sample(3'd0, 63'd9_000_000, 24'sd100);
    push_sample(3'd1, 63'd5_000_000, 24'sd100);
    evaluate_at(TS_MAX);
    wait_idle();
    // shrink: old entries stay visible until the step's next push
    write_reg(REG_WINDOW_LENGTH, 64'd1);
    evaluate_at(TS_MAX);
    push_sample(3'd0, 63'd9_500_000, 24'sd100);
    evaluate_at(TS_MAX);
  endtask

  task automatic test_random_chains();
    logic [TS_W-1:0]            base_ns;
    logic [TS_W-1:0]            ts;
    logic [CFG_DATA_W-1:0]      gains;
    logic signed [LAT_IN_W-1:0] lat;
    int                         phase;
    int                         item;
    int                         roll;
    int                         n;
    int                         used;
    int                         win;
    int                         s;
    int                         rnd;
    int                         ofs;
    for (phase = 0; phase < 6; phase++) begin
      wait_idle();
      if (phase == 0) n = 8;
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(0, 15);
      else n = $urandom_range(1, 8);
      used = (n == 0) ? 1 : (n > N_STEPS) ? N_STEPS : n;
      win = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      for (s = 0; s < N_STEPS; s++)
        gains[s*GAIN_W +: GAIN_W] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                              : 8'($urandom_range(8, 32));
      ofs = $urandom_range(0, 4000);
      ofs = ofs - 2000;
      if ($urandom_range(0, 7) == 0) ofs = $urandom;
      write_reg(REG_STEP_COUNT, CFG_DATA_W'(n));
      write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(win));
      write_reg(REG_START_MASK, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(REG_GAIN_TABLE, gains);
      write_reg(REG_OFFSET, CFG_DATA_W'(ofs));
      write_reg(REG_THRESHOLD, ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom)
                                                           : CFG_DATA_W'($urandom_range(0, 20000)));
      gaps_on = (phase != 2);
      base_ns = rand_time() >> 1;
      rnd = 0;
      for (item = 0; item < 75; item++) begin
        if (phase == 1 && item == 37) wait_idle();
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          push_sample(3'($urandom), rand_time(), LAT_IN_W'($urandom));
        end else if (roll < 28) begin
          if ($urandom_range(0, 9) == 0) evaluate_at(rand_time());
          else evaluate_at(base_ns + TS_W'(rnd) * ROUND_NS
                           + TS_W'($urandom_range(0, 36_000_000)));
        end else begin
          // samples laid out per round, later steps later in time, so chains form
          if ($urandom_range(0, 5) == 0) rnd++;
          s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, used - 1);
          lat = ($urandom_range(0, 9) == 0) ? LAT_IN_W'($urandom)
                                            : LAT_IN_W'($urandom_range(0, 3000));
          ts = base_ns + TS_W'(rnd) * ROUND_NS + TS_W'(s) * STRIDE_NS
               + TS_W'($urandom_range(0, 500_000));
          push_sample(3'(s), ts, lat);
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pend_wr == pend_rd) begin
        $error("result with no evaluate request pending: total_latency_us %0d",
               total_latency_us);
        err_count++;
      end else begin
        due = pending_totals[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (total_latency_us !== due.total) begin
          $error("total_latency_us: expected %0d, actual %0d", due.total, total_latency_us);
          err_count++;
        end
        if (missing_mask !== due.missing) begin
          $error("missing_mask: expected %02h, actual %02h", due.missing, missing_mask);
          err_count++;
        end
        if (status_code !== due.status) begin
          $error("status_code: expected %0d, actual %0d", due.status, status_code);
          err_count++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    start          <= 1'b0;
    command        <= CMD_RECORD;
    step_index     <= '0;
    sample_time_ns <= '0;
    latency_in_us  <= '0;
    now_ns         <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_STEP_COUNT;
    cfg_data       <= '0;
    model_cfg.step_count    = 4'd1;
    model_cfg.window_length = 5'd16;
    model_cfg.start_mask    = '0;
    model_cfg.gain_table    = 64'h1010_1010_1010_1010;
    model_cfg.offset_us     = '0;
    model_cfg.threshold_us  = '0;
    for (int s = 0; s < N_STEPS; s++) begin
      hist_fill[s] = '0;
      hist_wr[s]   = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_window_rules();
    test_random_chains();
    wait_idle();
    repeat (TAIL) @(posedge clk);
    if (err_count == 0 && pend_wr == pend_rd) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/plcs_pkg.sv
rtl/plcs_cfg_regs.sv
rtl/plcs_ctrl.sv
rtl/plcs_datapath.sv
rtl/pipeline_latency_chain_summer_unit.sv
tb/tb.sv
